// ----- hw/rtl/dip_pkg.sv -----
// Shared types and constants for the dense id pool with chained hash.
// No dependencies.
package dip_pkg;
    localparam int DefCapacity = 256;
    localparam int DefBuckets  = 512;

    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_FREE   = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;
endpackage

// ----- hw/rtl/dense_id_pool_chained_hash_top.sv -----
// Dense id pool with chained hash map: top level and sequencer.
// Depends on dip_pkg.
//
// One word is taken at a time and its result is held in an output register.
// Bucket heads live in one memory of BUCKETS entries and the entry store
// (key, prev, next) in a second memory of CAPACITY entries, both with a
// registered read. After reset a clearing pass writes the empty marker to
// every bucket head, one per cycle, while in_stall is high.
// Allocate reads the bucket head, writes the new entry and head and links the
// old head's prev. Free unlinks the entry and moves the last entry into the
// freed slot unless it was the last. Lookup walks the chain from the bucket
// head. A full allocate or out-of-range free goes straight to the result.
// Each step is bound by the single read port of the entry memory.
module dense_id_pool_chained_hash_top
    import dip_pkg::*;
#(
    parameter int CAPACITY = DefCapacity,
    parameter int BUCKETS  = DefBuckets
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  slot,
    input  logic [31:0] key_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  slot_index,
    output logic [31:0] object_id,
    output logic        moved
);
    localparam int SW = $clog2(CAPACITY + 1);   // slot or empty marker
    localparam int SI = $clog2(CAPACITY);       // slot index
    localparam int BW = $clog2(BUCKETS);
    localparam logic [SW-1:0] EMPTY = SW'(CAPACITY);
    localparam logic [SW-1:0] CAP   = SW'(CAPACITY);

    typedef struct packed {
        logic [31:0]   key;
        logic [SW-1:0] prev;
        logic [SW-1:0] next;
    } entry_t;

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_A_RD  = 14'b00000000000100,
        S_A_WR  = 14'b00000000001000,
        S_F_RD  = 14'b00000000010000,   // read freed entry
        S_F_P   = 14'b00000000100000,   // fix predecessor / head
        S_F_N   = 14'b00000001000000,   // fix successor
        S_F_L   = 14'b00000010000000,   // read last entry
        S_F_M   = 14'b00000100000000,   // fix pred / head of moved entry
        S_F_MN  = 14'b00001000000000,   // fix succ of moved entry
        S_L_H   = 14'b00010000000000,   // read bucket head / next chain link
        S_L_E   = 14'b00100000000000,   // read chain entry
        S_OUT   = 14'b01000000000000,
        S_WAIT  = 14'b10000000000000
    } state_t;

    // memories
    logic [SW-1:0] head_mem [BUCKETS];
    entry_t        ent_mem  [CAPACITY];

    logic          h_we;
    logic [BW-1:0] h_wa, h_ra;
    logic [SW-1:0] h_wd, h_rd;
    logic          e_we;
    logic [SI-1:0] e_wa, e_ra;
    entry_t        e_wd, e_rd;

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            head_mem[h_wa] <= h_wd;
        end
        h_rd <= head_mem[h_ra];
        if (e_we)
        begin
            ent_mem[e_wa] <= e_wd;
        end
        e_rd <= ent_mem[e_ra];
    end

    state_t        state_reg, state_next;
    logic [BW:0]   clr_reg, clr_next;
    logic [SW-1:0] count_reg, count_next;
    logic [31:0]   ctr_reg, ctr_next;
    logic [1:0]    func_reg;
    logic [SW-1:0] slot_reg;
    logic [31:0]   key_reg;
    entry_t        cur_reg, cur_next;      // entry being unlinked / moved
    logic [SW-1:0] idx_reg, idx_next;      // walk index
    logic [SW:0]   steps_reg, steps_next;
    logic [1:0]    st_reg, st_next;
    logic [7:0]    si_reg, si_next;
    logic [31:0]   oid_reg, oid_next;
    logic          mv_reg, mv_next;
    logic          ov_reg;
    logic          step_ok;                // chain walk step still in bound
    entry_t        lst_ent;                // last entry as read in S_F_L

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = ov_reg;
    assign status     = st_reg;
    assign slot_index = si_reg;
    assign object_id  = oid_reg;
    assign moved      = mv_reg;
    assign step_ok    = (idx_reg < count_reg) && (steps_reg < (SW+1)'(CAPACITY));

    // last entry: its prev link may have been written on the same edge it was read
    always_comb
    begin
        lst_ent = e_rd;
        if (cur_reg.next == count_reg)
        begin
            lst_ent.prev = cur_reg.prev;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        count_next = count_reg;
        ctr_next   = ctr_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        steps_next = steps_reg;
        st_next    = st_reg;
        si_next    = si_reg;
        oid_next   = oid_reg;
        mv_next    = mv_reg;
        h_we = 1'b0; h_wa = '0; h_wd = EMPTY; h_ra = '0;
        e_we = 1'b0; e_wa = '0; e_wd = cur_reg; e_ra = '0;
        case (state_reg)
            S_CLEAR:
            begin
                h_we = 1'b1;
                h_wa = clr_reg[BW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (BW+1)'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    st_next = ST_OK; si_next = '0; oid_next = '0; mv_next = 1'b0;
                    case (func)
                        FUNC_ALLOC:
                        begin
                            if (count_reg >= CAP)
                            begin
                                st_next = ST_FULL;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                h_ra = BW'(ctr_reg % BUCKETS);
                                state_next = S_A_RD;
                            end
                        end
                        FUNC_FREE:
                        begin
                            si_next = slot;
                            if (SW'(slot) >= count_reg)
                            begin
                                st_next = ST_RANGE;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                e_ra = SI'(slot);
                                state_next = S_F_RD;
                            end
                        end
                        FUNC_LOOKUP:
                        begin
                            h_ra = BW'(key_id % BUCKETS);
                            state_next = S_L_H;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            // allocate: write new entry and head; link old head's prev
            S_A_RD:
            begin
                e_we = 1'b1;
                e_wa = SI'(count_reg);
                e_wd.key  = ctr_reg;
                e_wd.prev = EMPTY;
                e_wd.next = (h_rd < CAP) ? h_rd : EMPTY;
                h_we = 1'b1;
                h_wa = BW'(ctr_reg % BUCKETS);
                h_wd = count_reg;
                idx_next = h_rd;
                e_ra = SI'(h_rd);
                state_next = S_A_WR;
            end
            S_A_WR:
            begin
                if (idx_reg < CAP)
                begin
                    e_we = 1'b1;
                    e_wa = SI'(idx_reg);
                    e_wd = e_rd;
                    e_wd.prev = count_reg;
                end
                si_next  = 8'(count_reg);
                oid_next = ctr_reg;
                ctr_next = ctr_reg + 1'b1;
                count_next = count_reg + 1'b1;
                state_next = S_OUT;
            end
            S_F_RD:
            begin
                cur_next = e_rd;
                e_ra = SI'(e_rd.prev);
                state_next = S_F_P;
            end
            S_F_P:
            begin
                // predecessor's next (or head) takes the freed entry's next
                if (cur_reg.prev < CAP)
                begin
                    e_we = 1'b1;
                    e_wa = SI'(cur_reg.prev);
                    e_wd = e_rd;
                    e_wd.next = cur_reg.next;
                end
                else
                begin
                    h_we = 1'b1;
                    h_wa = BW'(cur_reg.key % BUCKETS);
                    h_wd = cur_reg.next;
                end
                e_ra = SI'(cur_reg.next);
                state_next = S_F_N;
            end
            S_F_N:
            begin
                if (cur_reg.next < CAP)
                begin
                    e_we = 1'b1;
                    e_wa = SI'(cur_reg.next);
                    e_wd = e_rd;
                    e_wd.prev = cur_reg.prev;
                end
                count_next = count_reg - 1'b1;
                if (slot_reg == count_reg - 1'b1)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    e_ra = SI'(count_reg - 1'b1);
                    state_next = S_F_L;
                end
            end
            S_F_L:
            begin
                // last entry moves into the freed slot
                cur_next = lst_ent;
                e_we = 1'b1;
                e_wa = SI'(slot_reg);
                e_wd = lst_ent;
                e_ra = SI'(lst_ent.prev);
                state_next = S_F_M;
            end
            S_F_M:
            begin
                if (cur_reg.prev < CAP)
                begin
                    e_we = 1'b1;
                    e_wa = SI'(cur_reg.prev);
                    e_wd = e_rd;
                    e_wd.next = slot_reg;
                end
                else
                begin
                    h_we = 1'b1;
                    h_wa = BW'(cur_reg.key % BUCKETS);
                    h_wd = slot_reg;
                end
                e_ra = SI'(cur_reg.next);
                state_next = S_F_MN;
            end
            S_F_MN:
            begin
                if (cur_reg.next < CAP)
                begin
                    e_we = 1'b1;
                    e_wa = SI'(cur_reg.next);
                    e_wd = e_rd;
                    e_wd.prev = slot_reg;
                end
                oid_next = cur_reg.key;
                mv_next  = 1'b1;
                state_next = S_OUT;
            end
            S_L_H:
            begin
                idx_next = h_rd;
                steps_next = '0;
                e_ra = SI'(h_rd);
                state_next = S_L_E;
            end
            S_L_E:
            begin
                if (!step_ok)
                begin
                    st_next = ST_NOT_FOUND;
                    state_next = S_OUT;
                end
                else if (e_rd.key == key_reg)
                begin
                    si_next = 8'(idx_reg);
                    state_next = S_OUT;
                end
                else
                begin
                    // re-issue read for the next link
                    idx_next = e_rd.next;
                    steps_next = steps_reg + 1'b1;
                    h_ra = '0;
                    state_next = S_L_H;
                end
            end
            S_OUT:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // walk continuation: read next link from S_L_H without bucket head
        if (state_reg == S_L_H && steps_reg != '0 && state_next == S_L_E)
        begin
            idx_next = idx_reg;
            steps_next = steps_reg;
            e_ra = SI'(idx_reg);
        end
    end

    // state and counters; steps non-zero means re-reading a chain link
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            ctr_reg   <= '0;
            ov_reg    <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            ctr_reg   <= ctr_next;
            steps_reg <= (state_reg == S_IDLE) ? '0 : steps_next;
            if (state_reg == S_OUT)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg <= func;
            slot_reg <= SW'(slot);
            key_reg  <= key_id;
        end
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        st_reg  <= st_next;
        si_reg  <= si_next;
        oid_reg <= oid_next;
        mv_reg  <= mv_next;
    end

    // the output register holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(object_id))
        else $error("result changed while stalled");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("live count beyond capacity");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("new word taken while result pending");
    a_moved: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && moved |-> func_reg == FUNC_FREE && status == ST_OK)
        else $error("moved flag on wrong operation");
endmodule
